>>> hw/rtl/sclp_pkg.sv
// Shared types and constants for the sprite clip and place block.
package sclp_pkg;
	localparam int unsigned MAX_SPRITE  = 256;
	localparam int unsigned FRAME_LIMIT = 16384;
	localparam int unsigned NUM_W       = 37;
	localparam int unsigned QUO_W       = 23;
	localparam int unsigned DEN_W       = 15;

	localparam logic [2:0] REG_CONTENT_X      = 3'd0;
	localparam logic [2:0] REG_CONTENT_Y      = 3'd1;
	localparam logic [2:0] REG_CONTENT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_CONTENT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH    = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd5;
	localparam logic [2:0] REG_SPRITE_WIDTH   = 3'd6;
	localparam logic [2:0] REG_SPRITE_HEIGHT  = 3'd7;

	typedef struct packed {
		logic       vis;
		logic [13:0] cx;
		logic [13:0] cy;
		logic [8:0]  cw;
		logic [8:0]  ch;
		logic [7:0]  ox;
		logic [7:0]  oy;
	} clip_t;
endpackage

>>> hw/rtl/sprite_clip_and_place.sv
// Top level: configuration registers, clip stage, multipliers, dividers, output.
// Sprite clip and place.
// An item on the input channel (pos_x, pos_y, valid/ready) is a sprite
// position in source pixels. One result item per input leaves on the output
// channel: the clipped rectangle, the bitmap offsets and the rectangle
// mapped into the content area in Q16.8 / Q15.8 fixed point.
// The pipeline holds one clip stage, one multiply stage, 23 divider
// stages that each resolve one quotient bit against the frame size, and
// the output register that adds the content origin.
// Throughput is one item per cycle unless the receiver stalls the output; the divider pipeline sets the depth.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must do so while
// no item is in flight (the block does not enforce it); they take effect on the next item.
// Reset clears all valid bits and loads the register defaults.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes in place and in_ready drops; nothing is lost.
module sprite_clip_and_place (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [16:0] pos_x,
	input  logic [16:0] pos_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        visible,
	output logic [13:0] clip_x,
	output logic [13:0] clip_y,
	output logic [8:0]  clip_w,
	output logic [8:0]  clip_h,
	output logic [7:0]  bmp_skip_x,
	output logic [7:0]  bmp_skip_y,
	output logic signed [24:0] dest_x,
	output logic signed [24:0] dest_y,
	output logic [22:0] dest_w,
	output logic [22:0] dest_h
);
	import sclp_pkg::*;

	localparam int unsigned DEPTH = QUO_W + 3;

	logic [23:0] content_x_q, content_y_q;
	logic [22:0] content_w_q, content_h_q;
	logic [14:0] frame_w_q, frame_h_q, fw, fh;
	logic [8:0]  sprite_w_q, sprite_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_x_q <= 24'd0;
			content_y_q <= 24'd0;
			content_w_q <= 23'd491520;
			content_h_q <= 23'd276480;
			frame_w_q <= 15'd1920;
			frame_h_q <= 15'd1080;
			sprite_w_q <= 9'd32;
			sprite_h_q <= 9'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CONTENT_X:      content_x_q <= cfg_data;
				REG_CONTENT_Y:      content_y_q <= cfg_data;
				REG_CONTENT_WIDTH:  content_w_q <= cfg_data[22:0];
				REG_CONTENT_HEIGHT: content_h_q <= cfg_data[22:0];
				REG_FRAME_WIDTH:    frame_w_q <= cfg_data[14:0];
				REG_FRAME_HEIGHT:   frame_h_q <= cfg_data[14:0];
				REG_SPRITE_WIDTH:   sprite_w_q <= cfg_data[8:0];
				REG_SPRITE_HEIGHT:  sprite_h_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign fw = ({17'd0, frame_w_q} > FRAME_LIMIT[31:0]) ? FRAME_LIMIT[14:0] : frame_w_q;
	assign fh = ({17'd0, frame_h_q} > FRAME_LIMIT[31:0]) ? FRAME_LIMIT[14:0] : frame_h_q;

	logic [DEPTH-1:0] vld_q;
	logic             adv;

	assign adv = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: clipping.
	clip_t clip_c, clip_s1, clip_s2;
	clip_t side_d [0:QUO_W];

	sclp_clip u_clip (
		.pos_x(pos_x), .pos_y(pos_y), .fw(fw), .fh(fh),
		.sw(sprite_w_q), .sh(sprite_h_q),
		.content_ok((content_w_q != 23'd0) && (content_h_q != 23'd0)),
		.clip(clip_c)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			clip_s1 <= clip_c;
		end
	end

	// Stage 2: products for the four scaled values.
	logic [NUM_W-1:0] px_s2, py_s2, pw_s2, ph_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			clip_s2 <= clip_s1;
			px_s2 <= {23'd0, clip_s1.cx} * {14'd0, content_w_q};
			py_s2 <= {23'd0, clip_s1.cy} * {14'd0, content_h_q};
			pw_s2 <= {28'd0, clip_s1.cw} * {14'd0, content_w_q};
			ph_s2 <= {28'd0, clip_s1.ch} * {14'd0, content_h_q};
		end
	end

	// Divider stages; the clip result rides alongside.
	logic [QUO_W-1:0] qx, qy, qw, qh;

	sclp_div u_div_x (.clk(clk), .en(adv), .num(px_s2), .den(fw), .quo(qx));
	sclp_div u_div_y (.clk(clk), .en(adv), .num(py_s2), .den(fh), .quo(qy));
	sclp_div u_div_w (.clk(clk), .en(adv), .num(pw_s2), .den(fw), .quo(qw));
	sclp_div u_div_h (.clk(clk), .en(adv), .num(ph_s2), .den(fh), .quo(qh));

	assign side_d[0] = clip_s2;
	for (genvar k = 0; k < QUO_W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_d[k+1] <= side_d[k];
			end
		end
	end

	// Output register; an invisible result has every field zero.
	clip_t side_o;
	logic  vis_o;
	assign side_o = side_d[QUO_W];
	assign vis_o = side_o.vis;

	always_ff @(posedge clk) begin
		if (adv) begin
			visible <= vis_o;
			clip_x <= vis_o ? side_o.cx : 14'd0;
			clip_y <= vis_o ? side_o.cy : 14'd0;
			clip_w <= vis_o ? side_o.cw : 9'd0;
			clip_h <= vis_o ? side_o.ch : 9'd0;
			bmp_skip_x <= vis_o ? side_o.ox : 8'd0;
			bmp_skip_y <= vis_o ? side_o.oy : 8'd0;
			dest_x <= vis_o ? ($signed({content_x_q[23], content_x_q}) + $signed({2'd0, qx}))
				: 25'sd0;
			dest_y <= vis_o ? ($signed({content_y_q[23], content_y_q}) + $signed({2'd0, qy}))
				: 25'sd0;
			dest_w <= vis_o ? qw : 23'd0;
			dest_h <= vis_o ? qh : 23'd0;
		end
	end
endmodule

>>> hw/rtl/sclp_clip.sv
// Clips the sprite rectangle against the source frame (combinational).
module sclp_clip (
	input  logic [16:0]        pos_x,
	input  logic [16:0]        pos_y,
	input  logic [14:0]        fw,
	input  logic [14:0]        fh,
	input  logic [8:0]         sw,
	input  logic [8:0]         sh,
	input  logic               content_ok,
	output sclp_pkg::clip_t    clip
);
	import sclp_pkg::*;

	logic        neg_x, neg_y, size_ok;
	logic [16:0] px_c, py_c, nx, ny;
	logic signed [18:0] w1, h1, wlim, hlim, w2, h2;

	always_comb begin
		neg_x = pos_x[16];
		neg_y = pos_y[16];
		px_c = neg_x ? 17'd0 : pos_x;
		py_c = neg_y ? 17'd0 : pos_y;
		nx = 17'd0 - pos_x;
		ny = 17'd0 - pos_y;
		w1 = $signed({10'd0, sw}) + (neg_x ? $signed({{2{pos_x[16]}}, pos_x}) : 19'sd0);
		h1 = $signed({10'd0, sh}) + (neg_y ? $signed({{2{pos_y[16]}}, pos_y}) : 19'sd0);
		wlim = $signed({4'd0, fw}) - $signed({2'd0, px_c});
		hlim = $signed({4'd0, fh}) - $signed({2'd0, py_c});
		w2 = (w1 > wlim) ? wlim : w1;
		h2 = (h1 > hlim) ? hlim : h1;
		size_ok = (sw != 9'd0) && (sh != 9'd0) && ({23'd0, sw} <= MAX_SPRITE[31:0])
			&& ({23'd0, sh} <= MAX_SPRITE[31:0]) && (fw != 15'd0) && (fh != 15'd0);
		clip.vis = content_ok && size_ok && (w2 > 19'sd0) && (h2 > 19'sd0);
		clip.cx = px_c[13:0];
		clip.cy = py_c[13:0];
		clip.cw = w2[8:0];
		clip.ch = h2[8:0];
		clip.ox = neg_x ? nx[7:0] : 8'd0;
		clip.oy = neg_y ? ny[7:0] : 8'd0;
	end
endmodule

>>> hw/rtl/sclp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module sclp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [sclp_pkg::NUM_W-1:0]    num,
	input  logic [sclp_pkg::DEN_W-1:0]    den,
	output logic [sclp_pkg::QUO_W-1:0]    quo
);
	import sclp_pkg::*;

	logic [DEN_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [NUM_W-1:0] num_s [0:QUO_W];

	// The quotient is known to fit in QUO_W bits, so the top bits start below den.
	assign rem_s[0] = {1'b0, num[NUM_W-1:QUO_W]};
	assign quo_s[0] = '0;
	assign num_s[0] = num;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           take;
		always_comb begin
			trial = {rem_s[k], num_s[k][QUO_W-1-k]};
			take = trial >= {1'b0, den};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], take};
				num_s[k+1] <= num_s[k];
			end
		end
	end

	assign quo = quo_s[QUO_W];
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sprite clip and place block.
module testbench;
	import sclp_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic        vis;
		logic [13:0] cx;
		logic [13:0] cy;
		logic [8:0]  cw;
		logic [8:0]  ch;
		logic [7:0]  ox;
		logic [7:0]  oy;
		logic [24:0] dx;
		logic [24:0] dy;
		logic [22:0] dw;
		logic [22:0] dh;
	} placement_t;

	typedef struct {
		int         px;
		int         py;
		bit         typed;
		placement_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [16:0] pos_x;
	logic [16:0] pos_y;
	logic        out_valid;
	logic        out_ready;
	logic        visible;
	logic [13:0] clip_x;
	logic [13:0] clip_y;
	logic [8:0]  clip_w;
	logic [8:0]  clip_h;
	logic [7:0]  bmp_skip_x;
	logic [7:0]  bmp_skip_y;
	logic signed [24:0] dest_x;
	logic signed [24:0] dest_y;
	logic [22:0] dest_w;
	logic [22:0] dest_h;

	// Testbench copy of the register file, masked to each register's width.
	logic [23:0] cfg_copy [8];
	placement_t  pending_placements [$];
	dir_row_t    dir_tab [$];
	int          mismatches;
	int          cycles;
	int          idle_pct;
	int          stall_pct;
	int          hold_cycles;

	sprite_clip_and_place dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic placement_t place_sprite(logic [16:0] px_in, logic [16:0] py_in);
		placement_t r;
		longint     px;
		longint     py;
		longint     fw;
		longint     fh;
		longint     sw;
		longint     sh;
		longint     ox;
		longint     oy;
		longint     cwid;
		longint     chgt;
		longint     dx;
		longint     dy;
		px = longint'($signed(px_in));
		py = longint'($signed(py_in));
		fw = cfg_copy[REG_FRAME_WIDTH];
		fh = cfg_copy[REG_FRAME_HEIGHT];
		if (fw > FRAME_LIMIT) fw = FRAME_LIMIT;
		if (fh > FRAME_LIMIT) fh = FRAME_LIMIT;
		sw = cfg_copy[REG_SPRITE_WIDTH];
		sh = cfg_copy[REG_SPRITE_HEIGHT];
		cwid = cfg_copy[REG_CONTENT_WIDTH];
		chgt = cfg_copy[REG_CONTENT_HEIGHT];
		ox = 0;
		oy = 0;
		r = '0;
		if (cwid == 0 || chgt == 0) return r;
		if (sw == 0 || sh == 0 || sw > MAX_SPRITE || sh > MAX_SPRITE || fw == 0 || fh == 0)
			return r;
		if (px < 0) begin
			ox = -px;
			sw += px;
			px = 0;
		end
		if (py < 0) begin
			oy = -py;
			sh += py;
			py = 0;
		end
		if (sw > fw - px) sw = fw - px;
		if (sh > fh - py) sh = fh - py;
		if (sw <= 0 || sh <= 0) return r;
		dx = longint'($signed(cfg_copy[REG_CONTENT_X])) + (px * cwid) / fw;
		dy = longint'($signed(cfg_copy[REG_CONTENT_Y])) + (py * chgt) / fh;
		r.vis = 1'b1;
		r.cx = px[13:0];
		r.cy = py[13:0];
		r.cw = sw[8:0];
		r.ch = sh[8:0];
		r.ox = ox[7:0];
		r.oy = oy[7:0];
		r.dx = dx[24:0];
		r.dy = dy[24:0];
		r.dw = 23'((sw * cwid) / fw);
		r.dh = 23'((sh * chgt) / fh);
		return r;
	endfunction

	// Register writes happen only once the pipeline has drained.
	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		in_valid <= 1'b0;
		wait (pending_placements.size() == 0);
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_CONTENT_X, REG_CONTENT_Y: cfg_copy[idx] = val;
			REG_CONTENT_WIDTH, REG_CONTENT_HEIGHT: cfg_copy[idx] = {1'b0, val[22:0]};
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_copy[idx] = {9'b0, val[14:0]};
			default: cfg_copy[idx] = {15'b0, val[8:0]};
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [23:0] cx, logic [23:0] cy, logic [23:0] cw,
			logic [23:0] ch, logic [23:0] fw, logic [23:0] fh, logic [23:0] sw,
			logic [23:0] sh);
		write_reg(REG_CONTENT_X, cx);
		write_reg(REG_CONTENT_Y, cy);
		write_reg(REG_CONTENT_WIDTH, cw);
		write_reg(REG_CONTENT_HEIGHT, ch);
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
		write_reg(REG_SPRITE_WIDTH, sw);
		write_reg(REG_SPRITE_HEIGHT, sh);
	endtask

	// Valid is dropped only when an idle gap follows, so it never toggles in one step.
	task automatic send_pos(logic [16:0] px, logic [16:0] py, bit typed, placement_t res);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		do @(posedge clk); while (!in_ready);
		pending_placements.push_back(typed ? res : place_sprite(px, py));
	endtask

	function automatic logic [16:0] pick_coord(int frame, int spr);
		int lo;
		int hi;
		if (frame > FRAME_LIMIT) frame = FRAME_LIMIT;
		if (frame == 0) frame = 64;
		if (spr == 0 || spr > MAX_SPRITE) spr = 32;
		lo = -spr - 4;
		hi = frame + 4;
		if ($urandom_range(9) < 7)
			return 17'(lo + int'($urandom_range(hi - lo)));
		return 17'($urandom);
	endfunction

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		placement_t got;
		placement_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {visible, clip_x, clip_y, clip_w, clip_h, bmp_skip_x, bmp_skip_y,
				dest_x, dest_y, dest_w, dest_h};
			if (pending_placements.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item: %p", got);
			end else begin
				want = pending_placements.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		int n_items;
		placement_t full;
		cycles = 0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_CONTENT_X;
		cfg_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		out_ready = 1'b0;
		cfg_copy[REG_CONTENT_X] = 24'd0;
		cfg_copy[REG_CONTENT_Y] = 24'd0;
		cfg_copy[REG_CONTENT_WIDTH] = 24'd491520;
		cfg_copy[REG_CONTENT_HEIGHT] = 24'd276480;
		cfg_copy[REG_FRAME_WIDTH] = 24'd1920;
		cfg_copy[REG_FRAME_HEIGHT] = 24'd1080;
		cfg_copy[REG_SPRITE_WIDTH] = 24'd32;
		cfg_copy[REG_SPRITE_HEIGHT] = 24'd32;

		// Reset defaults: a 1920x1080 frame onto a 1920.0x1080.0 content area, 32x32 sprite.
		full = '{1'b1, 14'd0, 14'd0, 9'd32, 9'd32, 8'd0, 8'd0, 25'd0, 25'd0,
			23'd8192, 23'd8192};
		dir_tab.push_back('{0, 0, 1'b1, full});
		dir_tab.push_back('{-65536, -65536, 1'b1, placement_t'('0)});
		dir_tab.push_back('{65535, 65535, 1'b1, placement_t'('0)});
		dir_tab.push_back('{-32, 0, 1'b1, placement_t'('0)});
		dir_tab.push_back('{0, 1080, 1'b1, placement_t'('0)});
		dir_tab.push_back('{1919, 1079, 1'b1, '{1'b1, 14'd1919, 14'd1079, 9'd1, 9'd1,
			8'd0, 8'd0, 25'd491264, 25'd276224, 23'd256, 23'd256}});
		dir_tab.push_back('{-31, -31, 1'b1, '{1'b1, 14'd0, 14'd0, 9'd1, 9'd1,
			8'd31, 8'd31, 25'd0, 25'd0, 23'd256, 23'd256}});
		dir_tab.push_back('{1888, 1048, 1'b1, '{1'b1, 14'd1888, 14'd1048, 9'd32, 9'd32,
			8'd0, 8'd0, 25'd483328, 25'd268288, 23'd8192, 23'd8192}});
		dir_tab.push_back('{-65536, 500, 1'b0, placement_t'('0)});
		dir_tab.push_back('{500, 65535, 1'b0, placement_t'('0)});
		dir_tab.push_back('{1900, -10, 1'b0, placement_t'('0)});
		dir_tab.push_back('{-5, 1070, 1'b0, placement_t'('0)});
		dir_tab.push_back('{963, 517, 1'b0, placement_t'('0)});
		dir_tab.push_back('{1, 1, 1'b0, placement_t'('0)});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_pos(17'(dir_tab[i].px), 17'(dir_tab[i].py), dir_tab[i].typed, dir_tab[i].res);

		for (int ph = 0; ph < 12; ph++) begin
			n_items = 220;
			case (ph)
				0: ;
				1: set_all(24'h800000, 24'h7fffff, 24'h7fffff, 24'd1, 24'd16384, 24'd16384,
					24'd256, 24'd256);
				2: set_all(24'h7fffff, 24'h800000, 24'd1, 24'h7fffff, 24'd32767, 24'd20000,
					24'd1, 24'd1);
				3: begin
					set_all(24'd100, 24'd100, 24'd0, 24'd5000, 24'd640, 24'd480, 24'd16, 24'd16);
					n_items = 40;
				end
				4: begin
					set_all(24'd0, 24'd0, 24'd5000, 24'd0, 24'd640, 24'd480, 24'd16, 24'd16);
					n_items = 40;
				end
				5: begin
					set_all(24'd0, 24'd0, 24'd5000, 24'd5000, 24'd640, 24'd480, 24'd0, 24'd511);
					n_items = 40;
				end
				6: begin
					set_all(24'd0, 24'd0, 24'd5000, 24'd5000, 24'd640, 24'd480, 24'd257, 24'd16);
					n_items = 40;
				end
				7: begin
					set_all(24'd0, 24'd0, 24'd5000, 24'd5000, 24'd0, 24'd0, 24'd16, 24'd16);
					n_items = 40;
				end
				8: set_all(24'hfff000, 24'd4000, 24'd70000, 24'd90000, 24'd1, 24'd1,
					24'd256, 24'd256);
				default: set_all(24'($urandom), 24'($urandom), 24'($urandom_range(1, 8388607)),
					24'($urandom_range(1, 8388607)), 24'($urandom_range(1, 2000)),
					24'($urandom_range(1, 2000)), 24'($urandom_range(1, 256)),
					24'($urandom_range(1, 256)));
			endcase
			idle_pct = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 22 : 0;
			stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 22 : 0;
			// Long receiver hold-off while items keep coming, to back the pipeline up.
			if (ph == 4 || ph == 8) hold_cycles = 300;
			repeat (n_items)
				send_pos(pick_coord(int'(cfg_copy[REG_FRAME_WIDTH]),
					int'(cfg_copy[REG_SPRITE_WIDTH])),
					pick_coord(int'(cfg_copy[REG_FRAME_HEIGHT]),
					int'(cfg_copy[REG_SPRITE_HEIGHT])), 1'b0, placement_t'('0));
		end

		in_valid <= 1'b0;
		wait (pending_placements.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_placements.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/sclp_pkg.sv
hw/rtl/sclp_clip.sv
hw/rtl/sclp_div.sv
hw/rtl/sprite_clip_and_place.sv
tb/sv/testbench.sv
